// File: rtl/scp_pkg.sv
// Shared types, register codes and arithmetic helpers for the S-curve profile evaluator.
package scp_pkg;

   localparam int FRACTION_BITS_DEF = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int CSR_DATA_W        = 64;
   localparam int REQ_DATA_W        = 32;
   localparam int RSP_DATA_W        = 88;
   localparam int PHASE_STAGES      = 10;
   localparam int PHASE_COUNT       = 7;

   localparam logic [31:0]        RECIP3       = 32'hAAAAAAAB;
   localparam logic [16:0]        PROGRESS_ONE = 17'd65536;
   localparam logic signed [34:0] MAG_POS      = 35'sd4294967295;
   localparam logic signed [34:0] MAG_NEG      = -35'sd4294967295;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ACCEL_TIMES = 3'd0,
      REG_CRUISE_TIME = 3'd1,
      REG_DECEL_TIMES = 3'd2,
      REG_TOTAL_TIME  = 3'd3,
      REG_START_SPEED = 3'd4,
      REG_END_SPEED   = 3'd5,
      REG_JERK_LIMIT  = 3'd6,
      REG_PATH_LENGTH = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_RUN    = 2'd0,
      KIND_BEFORE = 2'd1,
      KIND_AFTER  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [33:0] pos;
      logic signed [33:0] vel;
      logic signed [33:0] acc;
      logic [31:0]        left;
      logic [31:0]        d;
      logic [63:0]        p_v;
      logic [63:0]        p_a;
      logic [63:0]        p_j;
      logic [31:0]        vd;
      logic [31:0]        ad;
      logic [31:0]        jd;
      logic [31:0]        ad2;
      logic [31:0]        jd2;
      logic [31:0]        jd3;
      logic signed [33:0] tpos;
      logic signed [33:0] tvel;
   } phase_item_type;

   function automatic logic signed [33:0] sat_mag(input logic signed [34:0] x);
      logic signed [33:0] r;
      if (x > MAG_POS) begin
         r = 34'(MAG_POS);
      end else if (x < MAG_NEG) begin
         r = 34'(MAG_NEG);
      end else begin
         r = 34'(x);
      end
      return r;
   endfunction

   function automatic logic [31:0] mag(input logic signed [33:0] x);
      logic signed [33:0] a;
      a = (x < 0) ? -x : x;
      return a[31:0];
   endfunction

   function automatic logic signed [34:0] apply_sign(input logic neg, input logic [32:0] m);
      logic signed [34:0] v;
      v = $signed({2'b00, m});
      return neg ? -v : v;
   endfunction

endpackage

// File: rtl/s_curve_profile_evaluator.sv
// Top level of the S-curve profile evaluator: registers, phase chain, progress divider, output.
//
// Evaluates a seven-phase jerk-limited motion profile at each sample time and returns
// progress, feed speed (per minute) and acceleration. One sample is taken every cycle
// unless the result side stalls, which freezes the whole pipeline. Stages: one input stage,
// ten for each of the seven phases (three chained rounded 32x32 multiplies per phase) and
// nine for the progress divide, each after the first resolving two quotient bits.
// Registers must be written only while no sample is in flight; the block does not enforce this.
module s_curve_profile_evaluator #(
   parameter int FRACTION_BITS = scp_pkg::FRACTION_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [scp_pkg::REQ_DATA_W-1:0]   req_tdata,   // [31:0] sample_time
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [scp_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // [16:0] progress, [48:17] feed_speed,
                                                         // [80:49] acceleration
   input  logic                             csr_we,
   input  logic [scp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [scp_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NPH        = scp_pkg::PHASE_COUNT;
   localparam int DIV_STAGES = 8;
   localparam int DIV_STEP   = 2;

   typedef struct packed {
      scp_pkg::kind_type kind;
      logic              zero;
      logic              sat;
      logic [32:0]       rem;
      logic [15:0]       quo;
      logic [31:0]       feed;
      logic [31:0]       accel;
   } div_item_type;

   logic [63:0] accel_times_ff, decel_times_ff;
   logic [31:0] cruise_time_ff, total_time_ff, start_speed_ff, end_speed_ff;
   logic [31:0] jerk_limit_ff, path_length_ff;

   logic                    en;
   logic                    in_vld_ff;
   scp_pkg::phase_item_type in_item_ff, in_item_in;
   logic [31:0]             dur [NPH];
   logic                    ph_vld  [NPH+1];
   scp_pkg::phase_item_type ph_item [NPH+1];

   logic [DIV_STAGES:0] dv_vld_ff;
   div_item_type        dv_ff [DIV_STAGES+1];
   div_item_type        dv_in [DIV_STAGES+1];
   logic [31:0]         speed_sel;
   logic [37:0]         feed_prod;
   logic [16:0]         progress;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_times_ff <= '0;
         cruise_time_ff <= '0;
         decel_times_ff <= '0;
         total_time_ff  <= '0;
         start_speed_ff <= '0;
         end_speed_ff   <= '0;
         jerk_limit_ff  <= '0;
         path_length_ff <= 32'(64'(1) << FRACTION_BITS);
      end else if (csr_we) begin
         unique case (scp_pkg::csr_index_type'(csr_index))
            scp_pkg::REG_ACCEL_TIMES: accel_times_ff <= csr_wdata;
            scp_pkg::REG_CRUISE_TIME: cruise_time_ff <= csr_wdata[31:0];
            scp_pkg::REG_DECEL_TIMES: decel_times_ff <= csr_wdata;
            scp_pkg::REG_TOTAL_TIME:  total_time_ff  <= csr_wdata[31:0];
            scp_pkg::REG_START_SPEED: start_speed_ff <= csr_wdata[31:0];
            scp_pkg::REG_END_SPEED:   end_speed_ff   <= csr_wdata[31:0];
            scp_pkg::REG_JERK_LIMIT:  jerk_limit_ff  <= csr_wdata[31:0];
            scp_pkg::REG_PATH_LENGTH: path_length_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   assign en         = !dv_vld_ff[DIV_STAGES] || rsp_tready;
   assign req_tready = en;

   always_comb begin
      in_item_in      = '0;
      in_item_in.left = req_tdata[31:0];
      in_item_in.vel  = $signed({2'b00, start_speed_ff});
      if (req_tdata[31]) begin
         in_item_in.kind = scp_pkg::KIND_BEFORE;
      end else if (req_tdata[31:0] >= total_time_ff) begin
         in_item_in.kind = scp_pkg::KIND_AFTER;
      end else begin
         in_item_in.kind = scp_pkg::KIND_RUN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_item_ff <= in_item_in;
      end
   end

   assign dur[0] = accel_times_ff[63:32];
   assign dur[1] = accel_times_ff[31:0];
   assign dur[2] = accel_times_ff[63:32];
   assign dur[3] = cruise_time_ff;
   assign dur[4] = decel_times_ff[63:32];
   assign dur[5] = decel_times_ff[31:0];
   assign dur[6] = decel_times_ff[63:32];

   assign ph_vld[0]  = in_vld_ff;
   assign ph_item[0] = in_item_ff;

   for (genvar p = 0; p < NPH; p++) begin : g_phase
      scp_phase #(
         .FRACTION_BITS (FRACTION_BITS),
         .JERK_SIGN     ((p == 0 || p == 6) ? 1 : ((p == 2 || p == 4) ? -1 : 0))
      ) u_phase (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .in_vld   (ph_vld[p]),
         .in_item  (ph_item[p]),
         .dur      (dur[p]),
         .jerk     (jerk_limit_ff),
         .out_vld  (ph_vld[p+1]),
         .out_item (ph_item[p+1])
      );
   end

   always_comb begin
      case (ph_item[NPH].kind)
         scp_pkg::KIND_BEFORE: speed_sel = start_speed_ff;
         scp_pkg::KIND_AFTER:  speed_sel = end_speed_ff;
         default:              speed_sel = (ph_item[NPH].vel <= 0) ? 32'd0
                                                                   : ph_item[NPH].vel[31:0];
      endcase
      feed_prod = 38'(speed_sel) * 38'd60;

      dv_in[0]       = '0;
      dv_in[0].kind  = ph_item[NPH].kind;
      dv_in[0].zero  = (ph_item[NPH].pos <= 0);
      dv_in[0].sat   = (ph_item[NPH].pos >= $signed({2'b00, path_length_ff}));
      dv_in[0].rem   = {1'b0, ph_item[NPH].pos[31:0]};
      dv_in[0].feed  = (|feed_prod[37:32]) ? 32'hFFFFFFFF : feed_prod[31:0];
      if (ph_item[NPH].kind != scp_pkg::KIND_RUN) begin
         dv_in[0].accel = '0;
      end else if (ph_item[NPH].acc > 34'sd2147483647) begin
         dv_in[0].accel = 32'h7FFFFFFF;
      end else if (ph_item[NPH].acc < -34'sd2147483648) begin
         dv_in[0].accel = 32'h80000000;
      end else begin
         dv_in[0].accel = ph_item[NPH].acc[31:0];
      end

      for (int k = 1; k <= DIV_STAGES; k++) begin
         dv_in[k] = dv_ff[k-1];
         for (int b = 0; b < DIV_STEP; b++) begin
            dv_in[k].rem = {dv_in[k].rem[31:0], 1'b0};
            if (dv_in[k].rem >= {1'b0, path_length_ff}) begin
               dv_in[k].rem = dv_in[k].rem - {1'b0, path_length_ff};
               dv_in[k].quo = {dv_in[k].quo[14:0], 1'b1};
            end else begin
               dv_in[k].quo = {dv_in[k].quo[14:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= '0;
      end else if (en) begin
         dv_vld_ff <= {dv_vld_ff[DIV_STAGES-1:0], ph_vld[NPH]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_ff[k] <= dv_in[k];
         end
      end
   end

   always_comb begin
      case (dv_ff[DIV_STAGES].kind)
         scp_pkg::KIND_BEFORE: progress = '0;
         scp_pkg::KIND_AFTER:  progress = scp_pkg::PROGRESS_ONE;
         default: begin
            if (dv_ff[DIV_STAGES].zero) begin
               progress = '0;
            end else if (dv_ff[DIV_STAGES].sat) begin
               progress = scp_pkg::PROGRESS_ONE;
            end else begin
               progress = {1'b0, dv_ff[DIV_STAGES].quo};
            end
         end
      endcase
   end

   assign rsp_tvalid = dv_vld_ff[DIV_STAGES];
   assign rsp_tdata  = {7'd0, dv_ff[DIV_STAGES].accel, dv_ff[DIV_STAGES].feed, progress};

`ifndef SYNTHESIS
   a_progress_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[16:0] <= scp_pkg::PROGRESS_ONE)
      else $error("progress above one");

   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

   a_special_accel: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && dv_ff[DIV_STAGES].kind != scp_pkg::KIND_RUN |-> rsp_tdata[80:49] == 32'd0)
      else $error("nonzero acceleration outside the profile");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(ph_vld[NPH]) && $stable(dv_vld_ff))
      else $error("pipeline moved during stall");
`endif

endmodule

// File: rtl/scp_phase.sv
// One profile phase: clip, three rounded product chains, integrate position, speed and accel.
module scp_phase #(
   parameter int FRACTION_BITS = scp_pkg::FRACTION_BITS_DEF,
   parameter int JERK_SIGN     = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_vld,
   input  scp_pkg::phase_item_type in_item,
   input  logic [31:0]             dur,
   input  logic [31:0]             jerk,
   output logic                    out_vld,
   output scp_pkg::phase_item_type out_item
);

   localparam int  STAGES = scp_pkg::PHASE_STAGES;
   localparam logic NEG_S = (JERK_SIGN < 0);

   logic [STAGES-1:0]       vld_ff;
   scp_pkg::phase_item_type item_ff [STAGES];
   scp_pkg::phase_item_type item_in [STAGES];
   logic [31:0]             d_clip;
   logic [32:0]             jd3_half;

   function automatic logic [31:0] rnd(input logic [63:0] p);
      logic [64:0] s;
      s = {1'b0, p} + (65'(1) << (FRACTION_BITS - 1));
      s = s >> FRACTION_BITS;
      return (|s[64:32]) ? 32'hFFFFFFFF : s[31:0];
   endfunction

   assign d_clip   = (in_item.left < dur) ? in_item.left : dur;
   assign jd3_half = ({1'b0, item_ff[6].jd3} + 33'd3) >> 1;

   always_comb begin
      item_in[0]      = in_item;
      item_in[0].d    = d_clip;
      item_in[0].left = in_item.left - d_clip;

      item_in[1]     = item_ff[0];
      item_in[1].p_v = 64'(scp_pkg::mag(item_ff[0].vel)) * 64'(item_ff[0].d);
      item_in[1].p_a = 64'(scp_pkg::mag(item_ff[0].acc)) * 64'(item_ff[0].d);
      item_in[1].p_j = 64'(jerk) * 64'(item_ff[0].d);

      item_in[2]    = item_ff[1];
      item_in[2].vd = rnd(item_ff[1].p_v);
      item_in[2].ad = rnd(item_ff[1].p_a);
      item_in[2].jd = (JERK_SIGN == 0) ? 32'd0 : rnd(item_ff[1].p_j);

      item_in[3]     = item_ff[2];
      item_in[3].p_a = 64'(item_ff[2].ad) * 64'(item_ff[2].d);
      item_in[3].p_j = 64'(item_ff[2].jd) * 64'(item_ff[2].d);

      item_in[4]     = item_ff[3];
      item_in[4].ad2 = rnd(item_ff[3].p_a);
      item_in[4].jd2 = rnd(item_ff[3].p_j);

      item_in[5]     = item_ff[4];
      item_in[5].p_j = 64'(item_ff[4].jd2) * 64'(item_ff[4].d);

      item_in[6]     = item_ff[5];
      item_in[6].jd3 = rnd(item_ff[5].p_j);

      // divide by 6: halve with rounding offset, then multiply by 1/3
      item_in[7]     = item_ff[6];
      item_in[7].p_j = 64'(jd3_half[31:0]) * 64'(scp_pkg::RECIP3);

      item_in[8]      = item_ff[7];
      item_in[8].tpos = scp_pkg::sat_mag(
         scp_pkg::apply_sign(item_ff[7].vel < 0, {1'b0, item_ff[7].vd})
         + scp_pkg::apply_sign(item_ff[7].acc < 0, ({1'b0, item_ff[7].ad2} + 33'd1) >> 1)
         + scp_pkg::apply_sign(NEG_S, 33'(item_ff[7].p_j[63:33])));
      item_in[8].tvel = scp_pkg::sat_mag(
         scp_pkg::apply_sign(item_ff[7].acc < 0, {1'b0, item_ff[7].ad})
         + scp_pkg::apply_sign(NEG_S, ({1'b0, item_ff[7].jd2} + 33'd1) >> 1));
      item_in[8].acc  = scp_pkg::sat_mag(35'(item_ff[7].acc)
         + scp_pkg::apply_sign(NEG_S, {1'b0, item_ff[7].jd}));

      item_in[9]     = item_ff[8];
      item_in[9].pos = scp_pkg::sat_mag(35'(item_ff[8].pos) + 35'(item_ff[8].tpos));
      item_in[9].vel = scp_pkg::sat_mag(35'(item_ff[8].vel) + 35'(item_ff[8].tvel));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            item_ff[k] <= item_in[k];
         end
      end
   end

   assign out_vld  = vld_ff[STAGES-1];
   assign out_item = item_ff[STAGES-1];

endmodule
